### sv/iqma_pkg.sv
// Shared types and constants for the two-channel I/Q magnitude averager.
// Holds the transaction payload structs, register indexes and fixed widths.
// No dependencies.
`timescale 1ns / 1ps

package iqma_pkg;

    localparam int FIELD_WIDTH     = 32;
    localparam int MEAN_WIDTH      = 32;
    localparam int SUM_WIDTH       = 48;
    localparam int CFG_INDEX_WIDTH = 8;
    localparam int CFG_DATA_WIDTH  = 32;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SKIP_COUNT    = 8'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_AVERAGE_COUNT = 8'd1;

    typedef struct packed {
        logic signed [FIELD_WIDTH-1:0] in_phase_one;
        logic signed [FIELD_WIDTH-1:0] quadrature_one;
        logic signed [FIELD_WIDTH-1:0] in_phase_two;
        logic signed [FIELD_WIDTH-1:0] quadrature_two;
    } frame_t;

    typedef struct packed {
        logic [MEAN_WIDTH-1:0] mean_magnitude_one;
        logic [MEAN_WIDTH-1:0] mean_magnitude_two;
    } result_t;

    // Commands from the frame sequencer to each magnitude lane.
    typedef struct packed {
        logic start;
        logic accumulate;
        logic clear;
    } lane_cmd_t;

endpackage

### sv/iq_magnitude_averager_core.sv
// Top level of the two-channel I/Q magnitude averager: configuration
// registers, frame sequencer, two magnitude lanes and the merging divider.
// Depends on iqma_pkg, iqma_lane and iqma_merge.
`timescale 1ns / 1ps

// Each frame transaction carries I and Q for two channels. A capture drops
// its first skip_count frames, sums the integer magnitude floor(sqrt(I^2+Q^2))
// of the next average_count frames per channel, and then returns one result
// transaction with each sum divided by average_count (floor, saturated to
// 32 bits); writing 0 to average_count stores 1. The two lanes run side by
// side, so the one-bit-per-cycle square root in each lane sets the pace from
// one accepted frame to the next while the capture stays open. The closing
// frame of a capture also hands its sums to a 48-step divider, waiting while
// it is busy; the divider runs while the next frames come in, and when every
// frame closes a capture, the divider sets the pace. Configuration writes are
// always taken and must arrive while no frame is in flight.
module iq_magnitude_averager_core
    import iqma_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 32,
    parameter int COUNT_WIDTH  = 16
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       frame_valid,
    output logic                       frame_ready,
    input  frame_t                     frame,
    output logic                       result_valid,
    input  logic                       result_ready,
    output result_t                    result,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]  cfg_data
);

    localparam int CW = COUNT_WIDTH;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_START = 2'd1;
    localparam logic [1:0] S_LANES = 2'd2;
    localparam logic [1:0] S_HAND  = 2'd3;

    logic [1:0]  state_reg, state_next;
    logic [CW-1:0] skip_reg, avg_reg;
    logic [CW:0] counter_reg;
    logic        averaged_reg, finish_reg;
    frame_t      frame_reg;

    logic        frame_accept;
    logic [CW:0] counter_inc, capture_end;
    logic        finish_now;
    logic [CW-1:0] cfg_value;
    lane_cmd_t   cmd;
    logic        done_one, done_two;
    logic [SUM_WIDTH-1:0] sum_one, sum_two;
    logic        job_valid, job_ready;

    assign frame_accept = frame_valid && frame_ready;
    assign frame_ready  = (state_reg == S_IDLE);
    assign cfg_ready    = 1'b1;
    assign cfg_value    = cfg_data[CW-1:0];

    assign counter_inc = counter_reg + (CW+1)'(1);
    assign capture_end = {1'b0, skip_reg} + {1'b0, avg_reg};
    assign finish_now  = (counter_inc >= capture_end);

    assign cmd.start      = (state_reg == S_START);
    assign cmd.accumulate = averaged_reg;
    assign cmd.clear      = job_valid && job_ready;
    assign job_valid      = (state_reg == S_HAND);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (frame_accept) state_next = S_START;
            S_START: state_next = S_LANES;
            S_LANES:
            begin
                if (done_one && done_two)
                    state_next = finish_reg ? S_HAND : S_IDLE;
            end
            S_HAND:  if (job_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            skip_reg     <= '0;
            avg_reg      <= CW'(1);
            counter_reg  <= '0;
            averaged_reg <= 1'b0;
            finish_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_SKIP_COUNT:    skip_reg <= cfg_value;
                    REG_AVERAGE_COUNT: avg_reg  <= (cfg_value == '0) ? CW'(1) : cfg_value;
                    default:
                    begin
                    end
                endcase
            end
            if (frame_accept)
            begin
                averaged_reg <= (counter_reg >= {1'b0, skip_reg});
                finish_reg   <= finish_now;
                counter_reg  <= finish_now ? '0 : counter_inc;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (frame_accept)
            frame_reg <= frame;
    end

    iqma_lane #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_lane_one (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .in_phase   (frame_reg.in_phase_one),
        .quadrature (frame_reg.quadrature_one),
        .done       (done_one),
        .sum        (sum_one)
    );

    iqma_lane #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_lane_two (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .in_phase   (frame_reg.in_phase_two),
        .quadrature (frame_reg.quadrature_two),
        .done       (done_two),
        .sum        (sum_two)
    );

    iqma_merge #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_merge (
        .clk          (clk),
        .rst_n        (rst_n),
        .job_valid    (job_valid),
        .job_ready    (job_ready),
        .sum_one      (sum_one),
        .sum_two      (sum_two),
        .divisor      (avg_reg),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

### sv/iqma_lane.sv
// One magnitude lane: absolute values, squares, a bit-per-cycle square root
// and the 48-bit running sum of one channel. Depends on iqma_pkg.
`timescale 1ns / 1ps

module iqma_lane
    import iqma_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 32
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  lane_cmd_t              cmd,
    input  logic [FIELD_WIDTH-1:0] in_phase,
    input  logic [FIELD_WIDTH-1:0] quadrature,
    output logic                   done,
    output logic [SUM_WIDTH-1:0]   sum
);

    localparam int SW     = SAMPLE_WIDTH;
    localparam int ITER_W = $clog2(SW);

    localparam logic [2:0] L_IDLE   = 3'd0;
    localparam logic [2:0] L_SQUARE = 3'd1;
    localparam logic [2:0] L_ADD    = 3'd2;
    localparam logic [2:0] L_ROOT   = 3'd3;
    localparam logic [2:0] L_ACC    = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic [ITER_W-1:0] iter_reg;
    logic              acc_reg;
    logic [SW-1:0]     a_reg, b_reg;
    logic [2*SW-1:0]   sqa_reg, sqb_reg;
    logic [2*SW-1:0]   rad_reg;
    logic [SW+2:0]     rem_reg;
    logic [SW-1:0]     root_reg;
    logic [SUM_WIDTH-1:0] sum_reg;

    logic [SW-1:0] raw_i, raw_q, abs_i, abs_q;
    logic [SW+2:0] rem_shift, trial;
    logic          fits;

    assign raw_i = in_phase[SW-1:0];
    assign raw_q = quadrature[SW-1:0];
    // The most negative sample maps to 2^(SW-1), which still fits unsigned.
    assign abs_i = raw_i[SW-1] ? (~raw_i + SW'(1)) : raw_i;
    assign abs_q = raw_q[SW-1] ? (~raw_q + SW'(1)) : raw_q;

    // One digit of the restoring square root: bring down two radicand bits
    // and try subtracting 4*root + 1.
    assign rem_shift = {rem_reg[SW:0], rad_reg[2*SW-1:2*SW-2]};
    assign trial     = {1'b0, root_reg, 2'b01};
    assign fits      = (rem_shift >= trial);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            L_IDLE:   if (cmd.start) state_next = L_SQUARE;
            L_SQUARE: state_next = L_ADD;
            L_ADD:    state_next = L_ROOT;
            L_ROOT:   if (iter_reg == ITER_W'(SW - 1)) state_next = L_ACC;
            L_ACC:    state_next = L_IDLE;
            default:  state_next = L_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= L_IDLE;
            sum_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cmd.clear)
                sum_reg <= '0;
            else if (state_reg == L_ACC && acc_reg)
                sum_reg <= sum_reg + SUM_WIDTH'(root_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            L_IDLE:
            begin
                a_reg   <= abs_i;
                b_reg   <= abs_q;
                acc_reg <= cmd.accumulate;
            end
            L_SQUARE:
            begin
                sqa_reg <= (2*SW)'(a_reg) * (2*SW)'(a_reg);
                sqb_reg <= (2*SW)'(b_reg) * (2*SW)'(b_reg);
            end
            L_ADD:
            begin
                // Both squares are at most 2^(2SW-2), so the sum cannot carry out.
                rad_reg  <= sqa_reg + sqb_reg;
                rem_reg  <= '0;
                root_reg <= '0;
                iter_reg <= '0;
            end
            L_ROOT:
            begin
                rad_reg  <= {rad_reg[2*SW-3:0], 2'b00};
                rem_reg  <= fits ? (rem_shift - trial) : rem_shift;
                root_reg <= {root_reg[SW-2:0], fits};
                iter_reg <= iter_reg + ITER_W'(1);
            end
            default:
            begin
            end
        endcase
    end

    assign done = (state_reg == L_ACC);
    assign sum  = sum_reg;

endmodule

### sv/iqma_merge.sv
// Merging stage: divides both channel sums by the average count with two
// restoring dividers in lockstep, saturates, and holds the result register.
// Depends on iqma_pkg.
`timescale 1ns / 1ps

module iqma_merge
    import iqma_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   job_valid,
    output logic                   job_ready,
    input  logic [SUM_WIDTH-1:0]   sum_one,
    input  logic [SUM_WIDTH-1:0]   sum_two,
    input  logic [COUNT_WIDTH-1:0] divisor,
    output logic                   result_valid,
    input  logic                   result_ready,
    output result_t                result
);

    localparam int CW     = COUNT_WIDTH;
    localparam int STEP_W = $clog2(SUM_WIDTH);

    localparam logic [1:0] M_IDLE = 2'd0;
    localparam logic [1:0] M_DIV  = 2'd1;
    localparam logic [1:0] M_HOLD = 2'd2;

    logic [1:0]           state_reg, state_next;
    logic [STEP_W-1:0]    step_reg;
    logic [CW-1:0]        div_reg;
    logic [SUM_WIDTH-1:0] dq_one_reg, dq_two_reg;
    logic [CW-1:0]        rem_one_reg, rem_two_reg;
    logic                 valid_reg;
    result_t              result_reg;

    logic [CW:0]     shift_one, shift_two;
    logic            fit_one, fit_two;
    logic            load_out;
    logic [MEAN_WIDTH-1:0] mean_one, mean_two;

    assign shift_one = {rem_one_reg, dq_one_reg[SUM_WIDTH-1]};
    assign shift_two = {rem_two_reg, dq_two_reg[SUM_WIDTH-1]};
    assign fit_one   = (shift_one >= {1'b0, div_reg});
    assign fit_two   = (shift_two >= {1'b0, div_reg});

    // Quotients wider than the output saturate to all ones.
    assign mean_one = (dq_one_reg[SUM_WIDTH-1:MEAN_WIDTH] != '0) ? '1
                                                                 : dq_one_reg[MEAN_WIDTH-1:0];
    assign mean_two = (dq_two_reg[SUM_WIDTH-1:MEAN_WIDTH] != '0) ? '1
                                                                 : dq_two_reg[MEAN_WIDTH-1:0];

    assign load_out = (state_reg == M_HOLD) && (!valid_reg || result_ready);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            M_IDLE:  if (job_valid) state_next = M_DIV;
            M_DIV:   if (step_reg == STEP_W'(SUM_WIDTH - 1)) state_next = M_HOLD;
            M_HOLD:  if (load_out) state_next = M_IDLE;
            default: state_next = M_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= M_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
                valid_reg <= 1'b1;
            else if (result_ready)
                valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == M_IDLE && job_valid)
        begin
            dq_one_reg  <= sum_one;
            dq_two_reg  <= sum_two;
            div_reg     <= divisor;
            rem_one_reg <= '0;
            rem_two_reg <= '0;
            step_reg    <= '0;
        end
        else if (state_reg == M_DIV)
        begin
            rem_one_reg <= fit_one ? CW'(shift_one - {1'b0, div_reg}) : shift_one[CW-1:0];
            rem_two_reg <= fit_two ? CW'(shift_two - {1'b0, div_reg}) : shift_two[CW-1:0];
            dq_one_reg  <= {dq_one_reg[SUM_WIDTH-2:0], fit_one};
            dq_two_reg  <= {dq_two_reg[SUM_WIDTH-2:0], fit_two};
            step_reg    <= step_reg + STEP_W'(1);
        end
        if (load_out)
        begin
            result_reg.mean_magnitude_one <= mean_one;
            result_reg.mean_magnitude_two <= mean_two;
        end
    end

    assign job_ready    = (state_reg == M_IDLE);
    assign result_valid = valid_reg;
    assign result       = result_reg;

endmodule
